// File: design/dkfe_pkg.sv
// dkfe_pkg: shared types, codes, des tables and permutation functions
// for the dukpt future key engine; no dependencies
package dkfe_pkg;

   localparam int NUM_FUTURE_KEYS_DEF = 21;
   localparam int CNT_BITS = 21;
   localparam logic [63:0] NRKGP_MASK = 64'hC0C0C0C000000000;
   localparam logic [63:0] PIN_VARIANT = 64'h00000000000000FF;
   localparam logic [63:0] MAC_VARIANT = 64'h000000000000FF00;
   localparam int ONES_LIMIT = 10;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_PIN = 2'd1;
   localparam logic [1:0] CMD_MAC = 2'd2;
   localparam logic [1:0] CMD_BAD = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_LOADED,
      MODE_OVERFLOW
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH_A,
      ST_WAIT_A,
      ST_LAUNCH_B,
      ST_WAIT_B
   } seq_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] init_key_left;
      logic [63:0] init_key_right;
      logic [15:0] init_ksn_high;
      logic [63:0] init_ksn_low;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] work_key_left;
      logic [63:0] work_key_right;
      logic [15:0] ksn_high_out;
      logic [63:0] ksn_low_out;
   } rsp_item_type;

   typedef struct packed {
      logic        start;
      logic [63:0] key;
      logic [63:0] block;
   } des_cmd_type;

   localparam logic [6:0] IP_TAB [0:63] = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
      64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   localparam logic [6:0] FP_TAB [0:63] = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
      37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   localparam logic [5:0] E_TAB [0:47] = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
      16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   localparam logic [5:0] P_TAB [0:31] = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   localparam logic [6:0] PC1_TAB [0:55] = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
      60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
      29,21,13,5,28,20,12,4};
   localparam logic [5:0] PC2_TAB [0:47] = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};

   localparam logic [3:0] SBOX [0:7][0:63] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   function automatic logic [63:0] perm_ip(input logic [63:0] x);
      logic [63:0] o;
      o = '0;
      for (int i = 0; i < 64; i++) o[63-i] = x[64-int'(IP_TAB[i])];
      return o;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] x);
      logic [63:0] o;
      o = '0;
      for (int i = 0; i < 64; i++) o[63-i] = x[64-int'(FP_TAB[i])];
      return o;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] x);
      logic [55:0] o;
      o = '0;
      for (int i = 0; i < 56; i++) o[55-i] = x[64-int'(PC1_TAB[i])];
      return o;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] x);
      logic [47:0] o;
      o = '0;
      for (int i = 0; i < 48; i++) o[47-i] = x[56-int'(PC2_TAB[i])];
      return o;
   endfunction

   function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] sub);
      logic [47:0] e;
      logic [5:0]  six;
      logic [31:0] sout;
      logic [31:0] o;
      e = '0;
      for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(E_TAB[i])];
      e = e ^ sub;
      sout = '0;
      for (int b = 0; b < 8; b++) begin
         six = e[47-6*b -: 6];
         sout[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
      end
      o = '0;
      for (int i = 0; i < 32; i++) o[31-i] = sout[32-int'(P_TAB[i])];
      return o;
   endfunction

endpackage

// File: design/dkfe_des.sv
// dkfe_des: iterative single des encryption, one round per cycle
// depends on dkfe_pkg for tables and round functions
module dkfe_des (
   input  logic                  clock,
   input  logic                  reset,
   input  dkfe_pkg::des_cmd_type cmd,
   output logic                  done,
   output logic [63:0]           result
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [3:0]  round_ff, round_in;
   logic [55:0] cd_ff, cd_in;
   logic [63:0] lr_ff, lr_in;
   logic        single;
   logic [27:0] c_rot, d_rot;

   always_comb begin
      single = (round_ff == 4'd0) || (round_ff == 4'd1) || (round_ff == 4'd8) ||
               (round_ff == 4'd15);
      c_rot = single ? {cd_ff[54:28], cd_ff[55]} : {cd_ff[53:28], cd_ff[55:54]};
      d_rot = single ? {cd_ff[26:0], cd_ff[27]} : {cd_ff[25:0], cd_ff[27:26]};
      run_in = run_ff;
      done_in = 1'b0;
      round_in = round_ff;
      cd_in = cd_ff;
      lr_in = lr_ff;
      if (cmd.start) begin
         run_in = 1'b1;
         round_in = '0;
         cd_in = dkfe_pkg::perm_pc1(cmd.key);
         lr_in = dkfe_pkg::perm_ip(cmd.block);
      end else if (run_ff) begin
         cd_in = {c_rot, d_rot};
         lr_in = {lr_ff[31:0],
                  lr_ff[63:32] ^ dkfe_pkg::round_f(lr_ff[31:0],
                                                   dkfe_pkg::perm_pc2({c_rot, d_rot}))};
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd15) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         round_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         round_ff <= round_in;
      end
      cd_ff <= cd_in;
      lr_ff <= lr_in;
   end

   assign done = done_ff;
   assign result = dkfe_pkg::perm_fp({lr_ff[31:0], lr_ff[63:32]});

endmodule

// File: design/dukpt_future_key_engine.sv
// dukpt_future_key_engine: originator-side dukpt key engine, top level
// depends on dkfe_pkg and dkfe_des
//
// usage: drive req_item and raise start while busy is low; the item is taken
// at that clock edge. command load installs the initial key and ksn, request
// pin or mac returns the current future key under that variant and the ksn.
// every item gives exactly one result on rsp_item, marked by rsp_strobe for a
// single cycle, in the cycle after the item is taken. the receiver cannot stall.
// busy stays high while future keys are derived into the key store: a load
// derives all 21 keys; a request that refills derives j keys (j = lowest set
// counter bit), and a request that needs no refill leaves busy low. each
// derivation is two runs of the shared des unit plus sequencing.
// reset clears the mode to not loaded, the ksn, the counter and the key valid
// bits; a request before any load answers status missing.
module dukpt_future_key_engine #(
   parameter int NUM_FUTURE_KEYS = dkfe_pkg::NUM_FUTURE_KEYS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  dkfe_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output dkfe_pkg::rsp_item_type rsp_item
);

   localparam int IDX_W = $clog2(NUM_FUTURE_KEYS);
   localparam int CB = dkfe_pkg::CNT_BITS;
   localparam logic [63:0] CNT_MASK64 = {{(64-CB){1'b0}}, {CB{1'b1}}};

   dkfe_pkg::seq_state_type state_ff, state_in;
   dkfe_pkg::mode_type      mode_ff;
   dkfe_pkg::des_cmd_type   des_cmd;
   dkfe_pkg::rsp_item_type  rsp_ff;

   logic [63:0] future_left_ff [NUM_FUTURE_KEYS];
   logic [63:0] future_right_ff [NUM_FUTURE_KEYS];
   logic [NUM_FUTURE_KEYS-1:0] valid_ff;
   logic [15:0]   ksn_top_ff;
   logic [63:0]   ksn_bot_ff;
   logic [CB-1:0] counter_ff;
   logic [63:0]   base_ff;
   logic [63:0]   kl_ff, kr_ff, right_ff;
   logic [4:0]    pos_ff;
   logic          strobe_ff;
   logic          des_done;
   logic [63:0]   des_result;
   logic          accept;
   logic [4:0]    low_bit;
   logic [IDX_W-1:0] cur_idx, wr_idx;
   logic [CB-1:0] counter_next;
   logic [63:0]   data_word, variant;

   always_comb begin
      low_bit = '0;
      for (int i = CB - 1; i >= 0; i--) begin
         if (counter_ff[i]) low_bit = 5'(i);
      end
      cur_idx = IDX_W'(NUM_FUTURE_KEYS - 1) - IDX_W'(low_bit);
      wr_idx = IDX_W'(NUM_FUTURE_KEYS - 1) - IDX_W'(pos_ff);
      if ($countones(counter_ff) < dkfe_pkg::ONES_LIMIT) begin
         counter_next = counter_ff + CB'(1);
      end else begin
         counter_next = counter_ff + (CB'(1) << low_bit);
      end
      data_word = base_ff | (64'd1 << pos_ff);
      variant = (req_item.command == dkfe_pkg::CMD_PIN) ? dkfe_pkg::PIN_VARIANT
                                                        : dkfe_pkg::MAC_VARIANT;
   end

   assign accept = start && (state_ff == dkfe_pkg::ST_IDLE);
   assign busy = (state_ff != dkfe_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      des_cmd.start = 1'b0;
      des_cmd.key = kl_ff;
      des_cmd.block = data_word ^ kr_ff;
      unique case (state_ff)
         dkfe_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_item.command == dkfe_pkg::CMD_LOAD) begin
                  state_in = dkfe_pkg::ST_LAUNCH_A;
               end else if (mode_ff == dkfe_pkg::MODE_LOADED &&
                            req_item.command != dkfe_pkg::CMD_BAD && valid_ff[cur_idx] &&
                            $countones(counter_ff) < dkfe_pkg::ONES_LIMIT &&
                            low_bit != 5'd0) begin
                  state_in = dkfe_pkg::ST_LAUNCH_A;
               end
            end
         end
         dkfe_pkg::ST_LAUNCH_A: begin
            des_cmd.start = 1'b1;
            state_in = dkfe_pkg::ST_WAIT_A;
         end
         dkfe_pkg::ST_WAIT_A: begin
            if (des_done) state_in = dkfe_pkg::ST_LAUNCH_B;
         end
         dkfe_pkg::ST_LAUNCH_B: begin
            des_cmd.start = 1'b1;
            des_cmd.key = kl_ff ^ dkfe_pkg::NRKGP_MASK;
            des_cmd.block = data_word ^ kr_ff ^ dkfe_pkg::NRKGP_MASK;
            state_in = dkfe_pkg::ST_WAIT_B;
         end
         dkfe_pkg::ST_WAIT_B: begin
            if (des_done) begin
               state_in = (pos_ff == 5'd0) ? dkfe_pkg::ST_IDLE : dkfe_pkg::ST_LAUNCH_A;
            end
         end
         default: state_in = dkfe_pkg::ST_IDLE;
      endcase
   end

   dkfe_des u_des (
      .clock  (clock),
      .reset  (reset),
      .cmd    (des_cmd),
      .done   (des_done),
      .result (des_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dkfe_pkg::ST_IDLE;
         mode_ff <= dkfe_pkg::MODE_IDLE;
         valid_ff <= '0;
         ksn_top_ff <= '0;
         ksn_bot_ff <= '0;
         counter_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= accept;
         if (accept) begin
            rsp_ff.status <= dkfe_pkg::STATUS_OK;
            rsp_ff.work_key_left <= '0;
            rsp_ff.work_key_right <= '0;
            rsp_ff.ksn_high_out <= ksn_top_ff;
            rsp_ff.ksn_low_out <= ksn_bot_ff;
            if (req_item.command == dkfe_pkg::CMD_LOAD) begin
               ksn_top_ff <= req_item.init_ksn_high;
               ksn_bot_ff <= (req_item.init_ksn_low & ~CNT_MASK64) | 64'd1;
               base_ff <= req_item.init_ksn_low & ~CNT_MASK64;
               counter_ff <= CB'(1);
               valid_ff <= '0;
               mode_ff <= dkfe_pkg::MODE_LOADED;
               kl_ff <= req_item.init_key_left;
               kr_ff <= req_item.init_key_right;
               pos_ff <= 5'(CB - 1);
               rsp_ff.ksn_high_out <= req_item.init_ksn_high;
               rsp_ff.ksn_low_out <= (req_item.init_ksn_low & ~CNT_MASK64) | 64'd1;
            end else if (req_item.command == dkfe_pkg::CMD_BAD ||
                         mode_ff == dkfe_pkg::MODE_IDLE) begin
               rsp_ff.status <= dkfe_pkg::STATUS_MISSING;
            end else if (mode_ff == dkfe_pkg::MODE_OVERFLOW) begin
               rsp_ff.status <= dkfe_pkg::STATUS_OVERFLOW;
            end else if (!valid_ff[cur_idx]) begin
               rsp_ff.status <= dkfe_pkg::STATUS_MISSING;
            end else begin
               rsp_ff.work_key_left <= future_left_ff[cur_idx] ^ variant;
               rsp_ff.work_key_right <= future_right_ff[cur_idx] ^ variant;
               kl_ff <= future_left_ff[cur_idx];
               kr_ff <= future_right_ff[cur_idx];
               base_ff <= ksn_bot_ff;
               pos_ff <= low_bit - 5'd1;
               valid_ff[cur_idx] <= 1'b0;
               counter_ff <= counter_next;
               ksn_bot_ff <= (ksn_bot_ff & ~CNT_MASK64) | {{(64-CB){1'b0}}, counter_next};
               if (counter_next == '0) mode_ff <= dkfe_pkg::MODE_OVERFLOW;
            end
         end
         if (state_ff == dkfe_pkg::ST_WAIT_B && des_done) begin
            valid_ff[wr_idx] <= 1'b1;
            if (pos_ff != 5'd0) pos_ff <= pos_ff - 5'd1;
         end
      end
      if (state_ff == dkfe_pkg::ST_WAIT_A && des_done) begin
         right_ff <= des_result ^ kr_ff;
      end
      if (state_ff == dkfe_pkg::ST_WAIT_B && des_done) begin
         future_left_ff[wr_idx] <= des_result ^ kr_ff ^ dkfe_pkg::NRKGP_MASK;
         future_right_ff[wr_idx] <= right_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item = rsp_ff;

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for dukpt_future_key_engine
// depends on dkfe_pkg and the engine rtl; predicts every result with its own des model
module tb_top;

   localparam logic [20:0] CNT_MASK = 21'h1FFFFF;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int KEY_SLOTS = 21;
   localparam int SHIFTS [0:15] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic rsp_strobe;
   dkfe_pkg::req_item_type req_item = '0;
   dkfe_pkg::rsp_item_type rsp_item;

   // predicted engine state
   logic [63:0] store_left [KEY_SLOTS];
   logic [63:0] store_right [KEY_SLOTS];
   logic        store_valid [KEY_SLOTS] = '{default: 1'b0};
   logic [15:0] serial_top = '0;
   logic [63:0] serial_bottom = '0;
   logic [20:0] txn_counter = '0;
   dkfe_pkg::mode_type engine_mode = dkfe_pkg::MODE_IDLE;

   dkfe_pkg::rsp_item_type pending_rsp[$];
   int errors = 0;
   int idle_cycles = 0;
   int n_loads = 0, n_requests = 0, n_bad = 0, n_checked = 0;

   dukpt_future_key_engine i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   always #4 clock = ~clock;

   function automatic logic [63:0] des_block(input logic [63:0] key, input logic [63:0] blk);
      logic [55:0] cd;
      logic [27:0] c, d;
      logic [63:0] ipb, pre, o;
      logic [31:0] l, r, f, sout, nl;
      logic [47:0] sub, e;
      logic [5:0]  six;
      for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(dkfe_pkg::PC1_TAB[i])];
      c = cd[55:28];
      d = cd[27:0];
      for (int i = 0; i < 64; i++) ipb[63-i] = blk[64-int'(dkfe_pkg::IP_TAB[i])];
      l = ipb[63:32];
      r = ipb[31:0];
      for (int rnd = 0; rnd < 16; rnd++) begin
         for (int s = 0; s < SHIFTS[rnd]; s++) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end
         cd = {c, d};
         for (int i = 0; i < 48; i++) sub[47-i] = cd[56-int'(dkfe_pkg::PC2_TAB[i])];
         for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(dkfe_pkg::E_TAB[i])];
         e = e ^ sub;
         for (int b = 0; b < 8; b++) begin
            six = e[47-6*b -: 6];
            sout[31-4*b -: 4] = dkfe_pkg::SBOX[b][{six[5], six[0]} * 16 + six[4:1]];
         end
         for (int i = 0; i < 32; i++) f[31-i] = sout[32-int'(dkfe_pkg::P_TAB[i])];
         nl = r;
         r = l ^ f;
         l = nl;
      end
      pre = {r, l};
      for (int i = 0; i < 64; i++) o[63-i] = pre[64-int'(dkfe_pkg::FP_TAB[i])];
      return o;
   endfunction

   task automatic derive_key(input logic [63:0] kl, input logic [63:0] kr, input int p);
      logic [63:0] data, ml, mr;
      int idx;
      idx = KEY_SLOTS - 1 - p;
      data = serial_bottom | (64'd1 << p);
      ml = kl ^ dkfe_pkg::NRKGP_MASK;
      mr = kr ^ dkfe_pkg::NRKGP_MASK;
      store_right[idx] = des_block(kl, data ^ kr) ^ kr;
      store_left[idx] = des_block(ml, data ^ mr) ^ mr;
      store_valid[idx] = 1'b1;
   endtask

   task automatic set_counter(input logic [20:0] v);
      txn_counter = v;
      serial_bottom = {serial_bottom[63:21], v};
   endtask

   task automatic engine_step(input dkfe_pkg::req_item_type it,
                              output dkfe_pkg::rsp_item_type rs);
      int j, ones, cur;
      logic [63:0] var_mask, kl, kr;
      rs = '0;
      rs.status = dkfe_pkg::STATUS_OK;
      if (it.command == dkfe_pkg::CMD_LOAD) begin
         serial_top = it.init_ksn_high;
         serial_bottom = it.init_ksn_low & ~{43'd0, CNT_MASK};
         txn_counter = '0;
         for (int i = 0; i < KEY_SLOTS; i++) store_valid[i] = 1'b0;
         for (int p = KEY_SLOTS - 1; p >= 0; p--)
            derive_key(it.init_key_left, it.init_key_right, p);
         set_counter(21'd1);
         engine_mode = dkfe_pkg::MODE_LOADED;
      end else if (it.command == dkfe_pkg::CMD_BAD || engine_mode == dkfe_pkg::MODE_IDLE) begin
         rs.status = dkfe_pkg::STATUS_MISSING;
      end else if (engine_mode == dkfe_pkg::MODE_OVERFLOW) begin
         rs.status = dkfe_pkg::STATUS_OVERFLOW;
      end else begin
         j = 0;
         while (j < KEY_SLOTS - 1 && !txn_counter[j]) j++;
         if (!txn_counter[j]) j = 0;
         cur = KEY_SLOTS - 1 - j;
         if (!store_valid[cur]) begin
            rs.status = dkfe_pkg::STATUS_MISSING;
         end else begin
            var_mask = (it.command == dkfe_pkg::CMD_PIN) ? dkfe_pkg::PIN_VARIANT
                                                         : dkfe_pkg::MAC_VARIANT;
            kl = store_left[cur];
            kr = store_right[cur];
            rs.work_key_left = kl ^ var_mask;
            rs.work_key_right = kr ^ var_mask;
            rs.ksn_high_out = serial_top;
            rs.ksn_low_out = serial_bottom;
            ones = $countones(txn_counter);
            if (ones < dkfe_pkg::ONES_LIMIT) begin
               for (int p = j - 1; p >= 0; p--) derive_key(kl, kr, p);
               store_valid[cur] = 1'b0;
               set_counter(txn_counter + 21'd1);
            end else begin
               store_valid[cur] = 1'b0;
               set_counter(txn_counter + (21'd1 << j));
            end
            if (txn_counter == '0) engine_mode = dkfe_pkg::MODE_OVERFLOW;
            return;
         end
      end
      rs.ksn_high_out = (engine_mode == dkfe_pkg::MODE_IDLE) ? 16'd0 : serial_top;
      rs.ksn_low_out = (engine_mode == dkfe_pkg::MODE_IDLE) ? 64'd0 : serial_bottom;
   endtask

   // acceptance, checking and watchdog
   always @(posedge clock) begin
      dkfe_pkg::rsp_item_type want, got;
      if (!reset) begin
         if (rsp_strobe) begin
            got = rsp_item;
            if (pending_rsp.size() == 0) begin
               $error("result with no item outstanding");
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               n_checked++;
               if (got.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, got.status);
                  errors++;
               end
               if (got.work_key_left !== want.work_key_left) begin
                  $error("work_key_left exp %h got %h", want.work_key_left, got.work_key_left);
                  errors++;
               end
               if (got.work_key_right !== want.work_key_right) begin
                  $error("work_key_right exp %h got %h", want.work_key_right,
                         got.work_key_right);
                  errors++;
               end
               if (got.ksn_high_out !== want.ksn_high_out) begin
                  $error("ksn_high_out exp %h got %h", want.ksn_high_out, got.ksn_high_out);
                  errors++;
               end
               if (got.ksn_low_out !== want.ksn_low_out) begin
                  $error("ksn_low_out exp %h got %h", want.ksn_low_out, got.ksn_low_out);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            engine_step(req_item, want);
            pending_rsp.push_back(want);
         end
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_rsp.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(input dkfe_pkg::req_item_type it);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item = it;
      start = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      @(negedge clock);
      case (it.command)
         dkfe_pkg::CMD_LOAD: n_loads++;
         dkfe_pkg::CMD_BAD: n_bad++;
         default: n_requests++;
      endcase
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic send_load(input logic [63:0] kl, input logic [63:0] kr,
                            input logic [15:0] kh, input logic [63:0] ksl);
      dkfe_pkg::req_item_type it;
      it.command = dkfe_pkg::CMD_LOAD;
      it.init_key_left = kl;
      it.init_key_right = kr;
      it.init_ksn_high = kh;
      it.init_ksn_low = ksl;
      send_item(it);
   endtask

   task automatic send_cmd(input logic [1:0] cmd, input bit noisy);
      dkfe_pkg::req_item_type it;
      it = noisy ? {cmd, rand64(), rand64(), 16'($urandom), rand64()} : '0;
      it.command = cmd;
      send_item(it);
   endtask

   task automatic send_random_request();
      int r;
      r = $urandom_range(0, 19);
      send_cmd(r == 0 ? dkfe_pkg::CMD_BAD : (r < 10 ? dkfe_pkg::CMD_PIN : dkfe_pkg::CMD_MAC), 1);
   endtask

   task automatic test_before_load();
      send_cmd(dkfe_pkg::CMD_PIN, 0);
      send_cmd(dkfe_pkg::CMD_MAC, 1);
      send_cmd(dkfe_pkg::CMD_BAD, 1);
   endtask

   task automatic test_load_extremes();
      send_load('0, '0, '0, '0);
      repeat (4) send_cmd(dkfe_pkg::CMD_PIN, 0);
      send_cmd(dkfe_pkg::CMD_BAD, 0);
      send_load('1, '1, '1, '1);
      repeat (4) send_cmd(dkfe_pkg::CMD_MAC, 1);
      send_load(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 16'hFFFF, 64'h9876543210E00000);
      repeat (6) send_cmd($urandom_range(0, 1) ? dkfe_pkg::CMD_PIN : dkfe_pkg::CMD_MAC, 1);
      wait_drained();
   endtask

   // long run without reload so refills reach the higher counter bits
   task automatic test_long_sequence();
      send_load(rand64(), rand64(), 16'($urandom), rand64());
      repeat (480) send_cmd($urandom_range(0, 1) ? dkfe_pkg::CMD_PIN : dkfe_pkg::CMD_MAC, 1);
      wait_drained();
   endtask

   task automatic test_random_mix();
      repeat (12) begin
         send_load(rand64(), rand64(), 16'($urandom), rand64());
         repeat ($urandom_range(5, 35)) send_random_request();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_before_load();
      test_load_extremes();
      test_long_sequence();
      test_random_mix();
      wait_drained();
      repeat (50) @(posedge clock);
      $display("covered %0d loads, %0d key requests, %0d bad commands; %0d results checked",
               n_loads, n_requests, n_bad, n_checked);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, pending_rsp.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
design/dkfe_pkg.sv
design/dkfe_des.sv
design/dukpt_future_key_engine.sv
bench/tb_top.sv
